### design/mrst_pkg.sv
// Types, codes and constants shared by the MESI requester state table.
// No dependencies; imported by every module of the block.
package mrst_pkg;

  localparam int BlockCountDef = 1024;
  localparam int ReqW  = 2;
  localparam int BlkW  = 10;
  localparam int CoreW = 4;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_SHARED    = 2'd1,
    ST_EXCLUSIVE = 2'd2,
    ST_MODIFIED  = 2'd3
  } line_state_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPG  = 2'd3
  } bus_req_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } cache_acc_e;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_STORE    = 2'd1,
    REQ_FILL_RD  = 2'd2,
    REQ_FILL_RDX = 2'd3
  } req_kind_e;

  typedef struct packed {
    req_kind_e kind;
    logic      shared;
    logic      in_range;
  } req_t;

  typedef struct packed {
    bus_req_e         bus;
    logic [CoreW-1:0] core;
    cache_acc_e       acc;
    line_state_e      state;
    logic             err;
  } result_t;

endpackage

### design/mrst_state_mem.sv
// Line state memory: one 2-bit state per block, one read and one write port.
// Runs a clearing sweep after reset. Depends on mrst_pkg.
module mrst_state_mem import mrst_pkg::*; #(
  parameter int BlockCount = BlockCountDef,
  localparam int AddrW = $clog2(BlockCount)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output line_state_e      rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  line_state_e      wr_data_i,
  output logic             busy_o
);

  line_state_e      mem_q [BlockCount];
  line_state_e      rd_data_q;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             busy_q, busy_d;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + AddrW'(1);
      if (clr_q == AddrW'(BlockCount - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= ST_INVALID;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

### design/mrst_update.sv
// MESI requester transition: next line state and the result beat.
// Combinational; depends on mrst_pkg.
module mrst_update import mrst_pkg::*; (
  input  req_t             req_i,
  input  line_state_e      cur_i,
  input  logic [CoreW-1:0] core_id_i,
  output line_state_e      next_o,
  output result_t          res_o
);

  bus_req_e    bus;
  cache_acc_e  acc;
  line_state_e st;
  logic        err;

  always_comb begin
    bus = BUS_NONE;
    acc = ACC_NONE;
    st  = cur_i;
    err = 1'b0;
    unique case (req_i.kind)
      REQ_LOAD: begin
        if (cur_i == ST_INVALID) bus = BUS_RD;
        else acc = ACC_READ;
      end
      REQ_STORE: begin
        if (cur_i == ST_INVALID) begin
          bus = BUS_RDX;
        end else begin
          if (cur_i == ST_SHARED) bus = BUS_UPG;
          st  = ST_MODIFIED;
          acc = ACC_WRITE;
        end
      end
      REQ_FILL_RD: begin
        if (cur_i != ST_INVALID) begin
          err = 1'b1;
        end else begin
          acc = ACC_READ;
          st  = req_i.shared ? ST_SHARED : ST_EXCLUSIVE;
        end
      end
      REQ_FILL_RDX: begin
        if (cur_i != ST_INVALID) begin
          err = 1'b1;
        end else begin
          acc = ACC_WRITE;
          st  = ST_MODIFIED;
        end
      end
      default: ;
    endcase
  end

  assign next_o = st;

  always_comb begin
    if (req_i.in_range) begin
      res_o.bus   = bus;
      res_o.core  = (bus != BUS_NONE) ? core_id_i : '0;
      res_o.acc   = acc;
      res_o.state = st;
      res_o.err   = err;
    end else begin
      res_o.bus   = BUS_NONE;
      res_o.core  = '0;
      res_o.acc   = ACC_NONE;
      res_o.state = ST_INVALID;
      res_o.err   = 1'b0;
    end
  end

endmodule

### design/mesi_requester_state_table.sv
// Top level of the MESI requester state table: read stage, update stage, output register.
// Depends on mrst_pkg, mrst_state_mem and mrst_update.
//
//   channel | signals                               | direction
//   in      | in_valid_i/in_ready_o, req fields     | request beat into block
//   out     | out_valid_o/out_ready_i, result       | result beat out of block
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i   | core_id write
//
// One beat per cycle sustained while the output is not stalled. Each beat passes the registered
// memory read and the update stage into the output register; a write to the block being read
// in the same cycle is forwarded. After reset a clearing sweep of all BlockCount entries holds
// in_ready_o low. A stalled output holds the update stage, which in turn holds in_ready_o low.
module mesi_requester_state_table import mrst_pkg::*; #(
  parameter int BlockCount = BlockCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CoreW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ReqW-1:0]  req_type_i,
  input  logic [BlkW-1:0]  block_number_i,
  input  logic             shared_asserted_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       bus_request_o,
  output logic [CoreW-1:0] request_core_o,
  output logic [1:0]       cache_access_o,
  output logic [1:0]       block_state_o,
  output logic             protocol_error_o
);

  localparam int AddrW = $clog2(BlockCount);
  localparam int CmpW  = ((AddrW > BlkW) ? AddrW : BlkW) + 1;

  logic [CoreW-1:0] core_id_q;
  logic             busy;
  logic             in_fire;
  logic [CmpW-1:0]  blk_ext;
  logic             in_range;
  logic [AddrW-1:0] rd_addr;
  line_state_e      rd_data;

  logic             s1_valid_q;
  req_t             s1_req_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_adv;
  logic             fwd_hit_q;
  line_state_e      fwd_state_q;
  line_state_e      cur_state;
  line_state_e      next_state;
  result_t          res;
  logic             wr_en;

  logic             out_valid_q;
  result_t          out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_id_q <= '0;
    end else if (cfg_valid_i) begin
      core_id_q <= cfg_data_i;
    end
  end

  assign blk_ext  = CmpW'(block_number_i);
  assign in_range = blk_ext < CmpW'(BlockCount);
  assign rd_addr  = blk_ext[AddrW-1:0];

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~busy & (~s1_valid_q | s1_adv);
  assign in_fire    = in_valid_i & in_ready_o;
  assign wr_en      = s1_adv & s1_req_q.in_range;
  assign cur_state  = fwd_hit_q ? fwd_state_q : rd_data;

  mrst_state_mem #(
    .BlockCount(BlockCount)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(next_state),
    .busy_o   (busy)
  );

  mrst_update u_update (
    .req_i    (s1_req_q),
    .cur_i    (cur_state),
    .core_id_i(core_id_q),
    .next_o   (next_state),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      fwd_hit_q  <= wr_en & (s1_addr_q == rd_addr);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q.kind     <= req_kind_e'(req_type_i);
      s1_req_q.shared   <= shared_asserted_i;
      s1_req_q.in_range <= in_range;
      s1_addr_q         <= rd_addr;
      fwd_state_q       <= next_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bus_request_o    = out_q.bus;
  assign request_core_o   = out_q.core;
  assign cache_access_o   = out_q.acc;
  assign block_state_o    = out_q.state;
  assign protocol_error_o = out_q.err;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("request accepted during clearing sweep");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forward hit without item in update stage");

  a_err_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.err) |-> (out_q.bus == BUS_NONE && out_q.acc == ACC_NONE))
    else $error("protocol error beat carries a request or access");

  a_core_only_with_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.bus == BUS_NONE) |-> (out_q.core == '0))
    else $error("core id driven without bus request");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("update stage lost a stalled beat");
`endif

endmodule

### dv/mesi_requester_state_table_tb.sv
`timescale 1ns / 1ps
// Testbench for mesi_requester_state_table: directed and random request/fill traffic,
// checked beat by beat against a line-state predictor kept in the bench.
// Depends on mrst_pkg and the design files; needs nothing else.
module mesi_requester_state_table_tb;
  import mrst_pkg::*;

  localparam int BlockCount = BlockCountDef;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CoreW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ReqW-1:0]  req_type_i;
  logic [BlkW-1:0]  block_number_i;
  logic             shared_asserted_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       bus_request_o;
  logic [CoreW-1:0] request_core_o;
  logic [1:0]       cache_access_o;
  logic [1:0]       block_state_o;
  logic             protocol_error_o;

  mesi_requester_state_table #(.BlockCount(BlockCount)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .block_number_i   (block_number_i),
    .shared_asserted_i(shared_asserted_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bus_request_o    (bus_request_o),
    .request_core_o   (request_core_o),
    .cache_access_o   (cache_access_o),
    .block_state_o    (block_state_o),
    .protocol_error_o (protocol_error_o)
  );

  line_state_e      line_tbl [BlockCount];
  logic [CoreW-1:0] core_id_q;
  result_t          pending_results [$];
  result_t          head_r;
  int               fail_count;
  int               items_sent;
  int               burst_left;
  bit               gaps_on;
  bit               stall_on;
  int               hold_cycles;
  int               run_left;
  bit               run_ready;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic result_t predict_line(req_kind_e kind, logic [BlkW-1:0] blk,
                                           logic shr);
    result_t     r;
    line_state_e st;
    r = '0;
    st = line_tbl[blk];
    r.bus = BUS_NONE;
    r.acc = ACC_NONE;
    if (kind == REQ_LOAD || kind == REQ_STORE) begin
      if (st == ST_INVALID) begin
        r.bus = (kind == REQ_STORE) ? BUS_RDX : BUS_RD;
      end else if (kind == REQ_LOAD) begin
        r.acc = ACC_READ;
      end else begin
        if (st == ST_SHARED) r.bus = BUS_UPG;
        st = ST_MODIFIED;
        r.acc = ACC_WRITE;
      end
    end else if (st != ST_INVALID) begin
      r.err = 1'b1;
    end else if (kind == REQ_FILL_RD) begin
      r.acc = ACC_READ;
      st = shr ? ST_SHARED : ST_EXCLUSIVE;
    end else begin
      r.acc = ACC_WRITE;
      st = ST_MODIFIED;
    end
    line_tbl[blk] = st;
    r.core  = (r.bus != BUS_NONE) ? core_id_q : '0;
    r.state = st;
    return r;
  endfunction

  task automatic issue_req(req_kind_e kind, logic [BlkW-1:0] blk, logic shr);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end else begin
      @(negedge clk_i);
    end
    if (gaps_on) burst_left--;
    in_valid_i        <= 1'b1;
    req_type_i        <= kind;
    block_number_i    <= blk;
    shared_asserted_i <= shr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_line(kind, blk, shr));
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_core_id(logic [CoreW-1:0] id);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    core_id_q = id;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // load or store, then the matching fill if it missed, then a few hits
  task automatic run_sequence(logic [BlkW-1:0] blk);
    req_kind_e kind;
    kind = $urandom_range(0, 1) ? REQ_STORE : REQ_LOAD;
    issue_req(kind, blk, 1'($urandom_range(0, 1)));
    if (line_tbl[blk] == ST_INVALID)
      issue_req(kind == REQ_STORE ? REQ_FILL_RDX : REQ_FILL_RD, blk,
                1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3))
      issue_req($urandom_range(0, 1) ? REQ_STORE : REQ_LOAD, blk, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [BlkW-1:0] pick_block();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BlkW'(BlockCount - 1);
      2, 3:    return BlkW'($urandom_range(0, 7));
      default: return BlkW'($urandom_range(0, BlockCount - 1));
    endcase
  endfunction

  task automatic test_directed();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    write_core_id(4'hF);
    issue_req(REQ_LOAD, 10'd0, 1'b0);
    issue_req(REQ_FILL_RD, 10'd0, 1'b1);
    issue_req(REQ_LOAD, 10'd0, 1'b1);
    issue_req(REQ_STORE, 10'd0, 1'b0);
    issue_req(REQ_STORE, 10'd0, 1'b1);
    issue_req(REQ_LOAD, 10'd1023, 1'b1);
    issue_req(REQ_FILL_RD, 10'd1023, 1'b0);
    issue_req(REQ_LOAD, 10'd1023, 1'b0);
    issue_req(REQ_STORE, 10'd1023, 1'b0);
    issue_req(REQ_STORE, 10'd512, 1'b1);
    issue_req(REQ_FILL_RDX, 10'd512, 1'b1);
    issue_req(REQ_FILL_RD, 10'd512, 1'b0);
    issue_req(REQ_FILL_RDX, 10'd0, 1'b0);
    issue_req(REQ_FILL_RDX, 10'd1023, 1'b1);
    issue_req(REQ_STORE, 10'd341, 1'b0);
    issue_req(REQ_FILL_RD, 10'd341, 1'b1);
    issue_req(REQ_STORE, 10'd341, 1'b0);
    issue_req(REQ_FILL_RD, 10'd682, 1'b0);
    issue_req(REQ_FILL_RD, 10'd682, 1'b1);
    issue_req(REQ_LOAD, 10'd682, 1'b0);
    settle();
    write_core_id(4'h0);
    issue_req(REQ_LOAD, 10'd5, 1'b1);
    issue_req(REQ_STORE, 10'd6, 1'b0);
    issue_req(REQ_LOAD, 10'd341, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    int target;
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    for (int p = 0; p < phases; p++) begin
      case (p % 3)
        0:       write_core_id(4'hF);
        1:       write_core_id(CoreW'($urandom_range(1, 14)));
        default: write_core_id(4'h0);
      endcase
      gaps_on  = (p != 1);
      stall_on = (p != 2);
      target = items_sent + per_phase;
      while (items_sent < target) run_sequence(pick_block());
      settle();
    end
  endtask

  task automatic test_noise(int count);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    write_core_id(CoreW'($urandom_range(0, 15)));
    repeat (count)
      issue_req(req_kind_e'($urandom_range(0, 3)), BlkW'($urandom_range(0, BlockCount - 1)),
                1'($urandom_range(0, 1)));
    settle();
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    @(posedge clk_i);
    hold_cycles = 300;
    repeat (20) run_sequence(pick_block());
    settle();
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else if (!stall_on) begin
      out_ready_i <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_ready = ~run_ready;
        run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      run_left--;
      out_ready_i <= run_ready;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        head_r = pending_results.pop_front();
        if (bus_request_o !== head_r.bus) begin
          $error("bus_request: expected %0d, got %0d", head_r.bus, bus_request_o);
          fail_count++;
        end
        if (request_core_o !== head_r.core) begin
          $error("request_core: expected %0d, got %0d", head_r.core, request_core_o);
          fail_count++;
        end
        if (cache_access_o !== head_r.acc) begin
          $error("cache_access: expected %0d, got %0d", head_r.acc, cache_access_o);
          fail_count++;
        end
        if (block_state_o !== head_r.state) begin
          $error("block_state: expected %0d, got %0d", head_r.state, block_state_o);
          fail_count++;
        end
        if (protocol_error_o !== head_r.err) begin
          $error("protocol_error: expected %0d, got %0d", head_r.err, protocol_error_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    req_type_i        = '0;
    block_number_i    = '0;
    shared_asserted_i = 1'b0;
    out_ready_i       = 1'b1;
    core_id_q         = '0;
    fail_count        = 0;
    items_sent        = 0;
    burst_left        = 0;
    gaps_on           = 1'b0;
    stall_on          = 1'b0;
    hold_cycles       = 0;
    run_left          = 0;
    run_ready         = 1'b0;
    foreach (line_tbl[i]) line_tbl[i] = ST_INVALID;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_traffic(4, 220);
    test_backpressure();
    test_noise(100);
    test_random_traffic(1, 60);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
